[rtl/core/dielectric_fresnel_scatter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the dielectric Fresnel scatter block
// Short wrappers for the concurrent checks.
// Each one samples on clk and is switched off while rst is high.
// ---------------------------------------------------------------------------
`ifndef DIELECTRIC_FRESNEL_SCATTER_DEFINES_SVH
`define DIELECTRIC_FRESNEL_SCATTER_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define DFS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after its condition.
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dfs_pkg.sv]
// ---------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the dielectric Fresnel scatter block.
// ---------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  // Register indexes on the configuration port (paddr[2]).
  localparam logic REG_INDEX_OUTSIDE = 1'b0;
  localparam logic REG_INDEX_INSIDE  = 1'b1;

  localparam logic [15:0] INDEX_OUTSIDE_RESET = 16'd4096;
  localparam logic [15:0] INDEX_INSIDE_RESET  = 16'd6144;

  // Radicand and root widths of the refraction cosine.
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  // Fresnel ratio: quotient bits and operand width.
  localparam int RATIO_QW = 17;
  localparam int RATIO_W  = 48;

  // One classified word, passed from the front through the queue.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic        [15:0] u;
    logic        [15:0] e1;
    logic        [15:0] e2;
    logic        [15:0] c;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/dielectric_fresnel_scatter.sv]
// ---------------------------------------------------------------------------
// dielectric_fresnel_scatter
// Dielectric Fresnel reflect or refract sampling of a local-frame direction.
// ---------------------------------------------------------------------------
// Throughput: one word per clock; the pipeline never stalls because the
// receiver takes every result, so busy only rises if the front queue fills.
// The pipeline length is set by the 62-stage radicand divider, the 31-stage
// square root and the 17-stage Fresnel ratio dividers, one bit per stage.
// Reset (synchronous, rst high) empties the pipeline and the queue and loads
// the index registers with 1.0 outside and 1.5 inside.
`default_nettype none
`include "dielectric_fresnel_scatter_defines.svh"

module dielectric_fresnel_scatter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Command side: a word is taken when start is high and busy is low.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] dir_in_x,
  input  wire logic signed [15:0] dir_in_y,
  input  wire logic signed [15:0] dir_in_z,
  input  wire logic        [15:0] uniform_sample,
  // Result side: one word per done pulse.
  output logic                    done,
  output logic signed [15:0]      dir_out_x,
  output logic signed [15:0]      dir_out_y,
  output logic signed [15:0]      dir_out_z,
  output logic                    was_reflected,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Pipeline depth seen from the command port: front register, queue
  // register, three set-up stages, radicand divider, one fix-up stage,
  // square root, two product stages, ratio divider and two final stages.
  localparam int LATENCY = 1 + 1 + 3 + dfs_pkg::RAD_W + 1 + dfs_pkg::ROOT_W + 2
                         + dfs_pkg::RATIO_QW + 2;

  logic [15:0] index_outside;
  logic [15:0] index_inside;
  logic        cfg_write;

  // The port always completes in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_outside <= dfs_pkg::INDEX_OUTSIDE_RESET;
      index_inside  <= dfs_pkg::INDEX_INSIDE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        dfs_pkg::REG_INDEX_OUTSIDE: index_outside <= pwdata[15:0];
        dfs_pkg::REG_INDEX_INSIDE:  index_inside  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dfs_pkg::REG_INDEX_OUTSIDE: prdata = {16'b0, index_outside};
      dfs_pkg::REG_INDEX_INSIDE:  prdata = {16'b0, index_inside};
      default:                    prdata = '0;
    endcase
  end

  // The front classifies each word: it picks the side from the sign of z,
  // orders the two indices and forms the cosine magnitude.
  logic           front_valid;
  dfs_pkg::item_t front_item;
  logic           front_ready;

  dfs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .dir_in_x       (dir_in_x),
    .dir_in_y       (dir_in_y),
    .dir_in_z       (dir_in_z),
    .uniform_sample (uniform_sample),
    .index_outside  (index_outside),
    .index_inside   (index_inside),
    .item_valid     (front_valid),
    .item           (front_item),
    .item_ready     (front_ready)
  );

  // The queue decouples the front from the arithmetic back end.
  logic           back_valid;
  dfs_pkg::item_t back_item;
  logic           back_ready;

  dfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_item  (front_item),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_item   (back_item),
    .pop_ready  (back_ready)
  );

  // The back works out the reflectance, the refracted direction and the
  // choice between mirror and refraction, one word per clock.
  dfs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (back_valid),
    .item          (back_item),
    .item_ready    (back_ready),
    .done          (done),
    .dir_out_x     (dir_out_x),
    .dir_out_y     (dir_out_y),
    .dir_out_z     (dir_out_z),
    .was_reflected (was_reflected)
  );

  // Every result comes from a word taken exactly one pipeline depth earlier.
  `DFS_ASSERT_IMPLIES(a_done_after_accept, done, $past(start && !busy, LATENCY), "result without matching word")
  // The back drains the queue every cycle, so the front never has to hold.
  `DFS_ASSERT_IMPLIES(a_never_busy, 1'b1, !busy, "front stalled although the back never stalls")
  // A write to the outer index register lands in the next cycle.
  `DFS_ASSERT_NEXT(a_cfg_outside, cfg_write && (paddr[2] == dfs_pkg::REG_INDEX_OUTSIDE), index_outside == $past(pwdata[15:0]), "outer index write lost")

endmodule

`default_nettype wire

[rtl/core/dfs_front.sv]
// ---------------------------------------------------------------------------
// dfs_front
// Accepts a word, picks the side of the surface and the index order.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] dir_in_x,
  input  wire logic signed [15:0] dir_in_y,
  input  wire logic signed [15:0] dir_in_z,
  input  wire logic        [15:0] uniform_sample,
  input  wire logic        [15:0] index_outside,
  input  wire logic        [15:0] index_inside,
  output logic                    item_valid,
  output dfs_pkg::item_t          item,
  input  wire logic               item_ready
);

  logic [15:0] e1_sel;
  logic [15:0] e2_sel;
  logic        take;

  assign busy = item_valid && !item_ready;
  assign take = start && !busy;

  // A negative z means the ray leaves the inside; a zero index becomes 1 LSB.
  always_comb begin
    if (dir_in_z[15]) begin
      e1_sel = index_inside;
      e2_sel = index_outside;
    end else begin
      e1_sel = index_outside;
      e2_sel = index_inside;
    end
    if (e1_sel == 16'd0) e1_sel = 16'd1;
    if (e2_sel == 16'd0) e2_sel = 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.x  <= dir_in_x;
      item.y  <= dir_in_y;
      item.z  <= dir_in_z;
      item.u  <= uniform_sample;
      item.e1 <= e1_sel;
      item.e2 <= e2_sel;
      item.c  <= dir_in_z[15] ? 16'(~dir_in_z + 16'sd1) : 16'(dir_in_z);
    end
  end

endmodule

`default_nettype wire

[rtl/core/dfs_queue.sv]
// ---------------------------------------------------------------------------
// dfs_queue
// Small first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire dfs_pkg::item_t push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output dfs_pkg::item_t      pop_item,
  input  wire logic           pop_ready
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dfs_pkg::item_t entry [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

[rtl/core/dfs_div.sv]
// ---------------------------------------------------------------------------
// dfs_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_div #(
  parameter int QW = 17,
  parameter int RW = 49,
  parameter int DW = 48,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [RW-1:0] in_rem,
  input  wire logic [QW-2:0] in_bits,
  input  wire logic [DW-1:0] in_divisor,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic [RW-1:0] rem_q  [QW];
  logic [QW-2:0] bits_q [QW];
  logic [DW-1:0] div_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] rem_i;
    logic [QW-2:0] bits_i;
    logic [DW-1:0] div_i;
    logic [QW-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic          vld_i;
    logic [RW-1:0] div_ext;
    logic [RW-1:0] diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_i  = in_rem;
      assign bits_i = in_bits;
      assign div_i  = in_divisor;
      assign quo_i  = '0;
      assign side_i = in_side;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign bits_i = bits_q[k-1];
      assign div_i  = div_q[k-1];
      assign quo_i  = quo_q[k-1];
      assign side_i = side_q[k-1];
      assign vld_i  = vld_q[k-1];
    end

    assign div_ext = {{(RW-DW){1'b0}}, div_i};
    assign take    = (rem_i >= div_ext);
    assign diff    = take ? rem_i - div_ext : rem_i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= {diff[RW-2:0], bits_i[QW-2]};
      bits_q[k] <= {bits_i[QW-3:0], 1'b0};
      div_q[k]  <= div_i;
      quo_q[k]  <= {quo_i[QW-2:0], take};
      side_q[k] <= side_i;
    end
  end

  assign out_valid = vld_q[QW-1];
  assign out_quo   = quo_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

`default_nettype wire

[rtl/core/dfs_sqrt.sv]
// ---------------------------------------------------------------------------
// dfs_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_sqrt #(
  parameter int SW = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [dfs_pkg::RAD_W-1:0]  in_rad,
  input  wire logic [SW-1:0]              in_side,
  output logic                            out_valid,
  output logic [dfs_pkg::ROOT_W-1:0]      out_root,
  output logic [SW-1:0]                   out_side
);

  localparam int NS = dfs_pkg::ROOT_W;
  localparam int NW = dfs_pkg::RAD_W;
  localparam int MW = NS + 1;

  logic [MW-1:0] rem_q  [NS];
  logic [NS-1:0] root_q [NS];
  logic [NW-1:0] rad_q  [NS];
  logic [SW-1:0] side_q [NS];
  logic          vld_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [MW-1:0] rem_i;
    logic [NS-1:0] root_i;
    logic [NW-1:0] rad_i;
    logic [SW-1:0] side_i;
    logic          vld_i;
    logic [MW+1:0] rem_sh;
    logic [MW+1:0] trial;
    logic [MW+1:0] diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign side_i = in_side;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
      assign side_i = side_q[k-1];
      assign vld_i  = vld_q[k-1];
    end

    // The remainder stays at most twice the partial root.
    assign rem_sh = {rem_i, rad_i[NW-1:NW-2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = take ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= diff[MW-1:0];
      root_q[k] <= {root_i[NS-2:0], take};
      rad_q[k]  <= {rad_i[NW-3:0], 2'b00};
      side_q[k] <= side_i;
    end
  end

  assign out_valid = vld_q[NS-1];
  assign out_root  = root_q[NS-1];
  assign out_side  = side_q[NS-1];

endmodule

`default_nettype wire

[rtl/core/dfs_back.sv]
// ---------------------------------------------------------------------------
// dfs_back
// Fresnel reflectance, refraction and the reflect or refract decision.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire dfs_pkg::item_t item,
  output logic                item_ready,
  output logic                done,
  output logic signed [15:0]  dir_out_x,
  output logic signed [15:0]  dir_out_y,
  output logic signed [15:0]  dir_out_z,
  output logic                was_reflected
);

  localparam int RAD_W   = dfs_pkg::RAD_W;
  localparam int ROOT_W  = dfs_pkg::ROOT_W;
  localparam int RQW     = dfs_pkg::RATIO_QW;
  localparam int RTW     = dfs_pkg::RATIO_W;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic        [15:0] u;
    logic        [15:0] e1;
    logic        [15:0] e2;
    logic        [15:0] c;
    logic               tir;
  } sb_rad_t;

  typedef struct packed {
    logic signed [15:0] refl_x;
    logic signed [15:0] refl_y;
    logic signed [15:0] refr_x;
    logic signed [15:0] refr_y;
    logic signed [15:0] z;
    logic        [15:0] u;
    logic        [15:0] e1;
    logic        [15:0] e2;
    logic        [15:0] c;
    logic               tir;
  } sb_root_t;

  typedef struct packed {
    logic signed [15:0] refl_x;
    logic signed [15:0] refl_y;
    logic signed [15:0] refr_x;
    logic signed [15:0] refr_y;
    logic signed [15:0] z;
    logic signed [15:0] refr_z;
    logic        [15:0] u;
    logic               tir;
  } sb_fin_t;

  typedef struct packed {
    sb_fin_t fin;
    logic    dz_s;
  } sb_ratio_t;

  // Saturate a magnitude to 16 bits, as +mag or as -mag.
  function automatic logic signed [15:0] sat_mag(input logic [RAD_W-1:0] mag,
                                                 input logic positive);
    logic signed [15:0] r;
    if (positive) begin
      r = (mag > RAD_W'(32767)) ? 16'sh7FFF : signed'(mag[15:0]);
    end else begin
      r = (mag > RAD_W'(32768)) ? 16'sh8000 : signed'(16'(~mag[15:0] + 16'd1));
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_negate(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : 16'(-v);
  endfunction

  // The back never stalls.
  assign item_ready = 1'b1;

  // Stage B0: squares and the scaled side components.
  logic           v0;
  dfs_pkg::item_t it0;
  logic [30:0]    csq0;
  logic [31:0]    e1sq0;
  logic [31:0]    e2sq0;
  logic [31:0]    mx0;
  logic [31:0]    my0;
  logic [15:0]    ax;
  logic [15:0]    ay;

  assign ax = item.x[15] ? 16'(~item.x + 16'sd1) : 16'(item.x);
  assign ay = item.y[15] ? 16'(~item.y + 16'sd1) : 16'(item.y);

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= item_valid;
  end

  always_ff @(posedge clk) begin
    it0   <= item;
    csq0  <= 31'(item.c * item.c);
    e1sq0 <= item.e1 * item.e1;
    e2sq0 <= item.e2 * item.e2;
    mx0   <= item.e1 * ax;
    my0   <= item.e1 * ay;
  end

  // Stage B1: E1^2 * S.
  logic               v1;
  dfs_pkg::item_t     it1;
  logic signed [63:0] prod1;
  logic [31:0]        e2sq1;
  logic [31:0]        mx1;
  logic [31:0]        my1;
  logic signed [31:0] s0;

  assign s0 = 32'sd268435456 - signed'({1'b0, csq0});

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
  end

  always_ff @(posedge clk) begin
    it1   <= it0;
    prod1 <= 64'(signed'({1'b0, e1sq0}) * s0);
    e2sq1 <= e2sq0;
    mx1   <= mx0;
    my1   <= my0;
  end

  // Stage B2: N, the total internal reflection flag and the rounding dividends.
  logic               v2;
  logic [RAD_W-1:0]   n2;
  logic [31:0]        e2sq2;
  logic [32:0]        dx2;
  logic [32:0]        dy2;
  logic [15:0]        e2_2;
  sb_rad_t            sb2;
  logic signed [63:0] n1;

  assign n1 = signed'({4'b0, e2sq1, 28'b0}) - prod1;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    n2     <= n1[RAD_W-1:0];
    e2sq2  <= e2sq1;
    dx2    <= {mx1, 1'b0} + 33'(it1.e2);
    dy2    <= {my1, 1'b0} + 33'(it1.e2);
    e2_2   <= it1.e2;
    sb2.x  <= it1.x;
    sb2.y  <= it1.y;
    sb2.z  <= it1.z;
    sb2.u  <= it1.u;
    sb2.e1 <= it1.e1;
    sb2.e2 <= it1.e2;
    sb2.c  <= it1.c;
    sb2.tir <= n1[63];
  end

  // Radicand division and the two refraction scalings, side by side.
  logic             vr;
  logic [RAD_W-1:0] rad_q;
  sb_rad_t          sbr;
  logic             vx;
  logic             vy;
  logic [RAD_W-1:0] qx;
  logic [RAD_W-1:0] qy;
  logic             sx;
  logic             sy;

  dfs_div #(.QW(RAD_W), .RW(33), .DW(32), .SW($bits(sb_rad_t))) u_div_rad (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_rem     ({32'b0, n2[RAD_W-1]}),
    .in_bits    (n2[RAD_W-2:0]),
    .in_divisor (e2sq2),
    .in_side    (sb2),
    .out_valid  (vr),
    .out_quo    (rad_q),
    .out_side   (sbr)
  );

  dfs_div #(.QW(RAD_W), .RW(18), .DW(17), .SW(1)) u_div_x (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_rem     (18'b0),
    .in_bits    ({(RAD_W-34)'(0), dx2}),
    .in_divisor ({e2_2, 1'b0}),
    .in_side    (sb2.x[15]),
    .out_valid  (vx),
    .out_quo    (qx),
    .out_side   (sx)
  );

  dfs_div #(.QW(RAD_W), .RW(18), .DW(17), .SW(1)) u_div_y (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_rem     (18'b0),
    .in_bits    ({(RAD_W-34)'(0), dy2}),
    .in_divisor ({e2_2, 1'b0}),
    .in_side    (sb2.y[15]),
    .out_valid  (vy),
    .out_quo    (qy),
    .out_side   (sy)
  );

  // Stage R: saturated mirror and refraction components.
  logic             v3;
  logic [RAD_W-1:0] rad3;
  sb_root_t         sb3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= vr && vx && vy;
  end

  always_ff @(posedge clk) begin
    rad3       <= rad_q;
    sb3.refl_x <= sat_negate(sbr.x);
    sb3.refl_y <= sat_negate(sbr.y);
    sb3.refr_x <= sat_mag(qx, sx);
    sb3.refr_y <= sat_mag(qy, sy);
    sb3.z      <= sbr.z;
    sb3.u      <= sbr.u;
    sb3.e1     <= sbr.e1;
    sb3.e2     <= sbr.e2;
    sb3.c      <= sbr.c;
    sb3.tir    <= sbr.tir;
  end

  logic              vs;
  logic [ROOT_W-1:0] ct;
  sb_root_t          sbs;

  dfs_sqrt #(.SW($bits(sb_root_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_rad    (rad3),
    .in_side   (sb3),
    .out_valid (vs),
    .out_root  (ct),
    .out_side  (sbs)
  );

  // Stage P1: cross products of indices and cosines.
  logic        v4;
  logic [31:0] a4;
  logic [46:0] b4;
  logic [46:0] a4p;
  logic [31:0] b4p;
  sb_fin_t     sb4;
  logic        z_pos;

  assign z_pos = !sbs.z[15] && (sbs.z != 16'sd0);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= vs;
  end

  always_ff @(posedge clk) begin
    a4         <= sbs.e1 * sbs.c;
    b4         <= sbs.e2 * ct;
    a4p        <= sbs.e1 * ct;
    b4p        <= sbs.e2 * sbs.c;
    sb4.refl_x <= sbs.refl_x;
    sb4.refl_y <= sbs.refl_y;
    sb4.refr_x <= sbs.refr_x;
    sb4.refr_y <= sbs.refr_y;
    sb4.z      <= sbs.z;
    sb4.refr_z <= sat_mag({(RAD_W-ROOT_W)'(0), ct}, !z_pos);
    sb4.u      <= sbs.u;
    sb4.tir    <= sbs.tir;
  end

  // Stage P2: numerators and denominators of both ratios.
  logic           v5;
  logic [RTW-1:0] num_s5;
  logic [RTW-1:0] den_s5;
  logic [RTW-1:0] num_p5;
  logic [RTW-1:0] den_p5;
  logic           dz_p5;
  sb_ratio_t      sb5;
  logic [RTW-1:0] as_w;
  logic [RTW-1:0] bs_w;
  logic [RTW-1:0] ap_w;
  logic [RTW-1:0] bp_w;

  assign as_w = RTW'(a4);
  assign bs_w = RTW'(b4);
  assign ap_w = RTW'(a4p);
  assign bp_w = RTW'(b4p);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
  end

  always_ff @(posedge clk) begin
    num_s5   <= (as_w > bs_w) ? as_w - bs_w : bs_w - as_w;
    den_s5   <= as_w + bs_w;
    num_p5   <= (ap_w > bp_w) ? ap_w - bp_w : bp_w - ap_w;
    den_p5   <= ap_w + bp_w;
    dz_p5    <= (ap_w + bp_w) == '0;
    sb5.fin  <= sb4;
    sb5.dz_s <= (as_w + bs_w) == '0;
  end

  logic           vq_s;
  logic           vq_p;
  logic [RQW-1:0] q_s;
  logic [RQW-1:0] q_p;
  sb_ratio_t      sbq;
  logic           dz_pq;

  dfs_div #(.QW(RQW), .RW(RTW+1), .DW(RTW), .SW($bits(sb_ratio_t))) u_div_rs (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v5),
    .in_rem     ({1'b0, num_s5}),
    .in_bits    ((RQW-1)'(0)),
    .in_divisor (den_s5),
    .in_side    (sb5),
    .out_valid  (vq_s),
    .out_quo    (q_s),
    .out_side   (sbq)
  );

  dfs_div #(.QW(RQW), .RW(RTW+1), .DW(RTW), .SW(1)) u_div_rp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v5),
    .in_rem     ({1'b0, num_p5}),
    .in_bits    ((RQW-1)'(0)),
    .in_divisor (den_p5),
    .in_side    (dz_p5),
    .out_valid  (vq_p),
    .out_quo    (q_p),
    .out_side   (dz_pq)
  );

  // Stage S1: squares of the two amplitude ratios; a zero denominator means one.
  logic           v6;
  logic [33:0]    sq_s6;
  logic [33:0]    sq_p6;
  sb_fin_t        sb6;
  logic [RQW-1:0] rs_v;
  logic [RQW-1:0] rp_v;

  assign rs_v = sbq.dz_s ? RQW'(65536) : q_s;
  assign rp_v = dz_pq    ? RQW'(65536) : q_p;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= vq_s && vq_p;
  end

  always_ff @(posedge clk) begin
    sq_s6 <= rs_v * rs_v;
    sq_p6 <= rp_v * rp_v;
    sb6   <= sbq.fin;
  end

  // Stage S2: reflectance, decision and the result register.
  logic [34:0] fsum;
  logic [17:0] fres;
  logic        refl;

  assign fsum = {1'b0, sq_s6} + {1'b0, sq_p6};
  assign fres = fsum[34:17];
  assign refl = sb6.tir || ({2'b0, sb6.u} <= fres);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v6;
  end

  always_ff @(posedge clk) begin
    dir_out_x     <= refl ? sb6.refl_x : sb6.refr_x;
    dir_out_y     <= refl ? sb6.refl_y : sb6.refr_y;
    dir_out_z     <= refl ? sb6.z      : sb6.refr_z;
    was_reflected <= refl;
  end

endmodule

`default_nettype wire
